// File: sv/uart_rx_pkg.sv
`default_nettype none

package uart_rx_pkg;

    localparam int FrameLenW = 16;
    localparam int PosW      = 17;
    localparam int ByteW     = 8;
    localparam int WordW     = 9;
    localparam int CfgAddrW  = 2;
    localparam int CfgDataW  = 8;

    localparam logic [ByteW-1:0] DataMaskReset = 8'hFF;

    typedef enum logic [1:0] {
        OP_ARM     = 2'd0,
        OP_RX_CHAR = 2'd1,
        OP_ABANDON = 2'd2
    } opcode_t;

    typedef enum logic [1:0] {
        EV_NONE = 2'd0,
        EV_SOB  = 2'd1,
        EV_CPLT = 2'd2,
        EV_ABT  = 2'd3
    } event_t;

    typedef enum logic [CfgAddrW-1:0] {
        CFG_NINE_BIT  = 2'd0,
        CFG_END_MATCH = 2'd1,
        CFG_DATA_MASK = 2'd2
    } cfg_addr_t;

    typedef struct packed {
        logic [1:0]           opcode;
        logic [FrameLenW-1:0] frame_length;
        logic [WordW-1:0]     rx_word;
        logic                 match_flag;
        logic                 timeout_flag;
    } rx_in_t;

    typedef struct packed {
        logic [1:0]       event_res;
        logic             write_enable;
        logic [PosW-1:0]  write_position;
        logic [ByteW-1:0] write_byte;
        logic             zero_terminate;
    } rx_out_t;

endpackage

`default_nettype wire

// File: sv/uart_rx_frame_receiver_top.sv
`default_nettype none

// Receive deframer for a UART core. Every input beat (arm, received character
// or abandon) yields exactly one result beat: an event code, an optional byte
// store with its buffer position, and a zero-terminator request. The whole
// update of the frame state is done in the cycle of acceptance and lands in a
// single output register, so one beat is taken per clock and the result shows
// on the next cycle; s_ready only drops while that output register is full and
// m_ready is low. Configuration is written through cfg_wr_en/cfg_addr/cfg_wdata
// and must only change while no result is outstanding.
module uart_rx_frame_receiver_top (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              cfg_wr_en,
    input  wire logic [uart_rx_pkg::CfgAddrW-1:0]  cfg_addr,
    input  wire logic [uart_rx_pkg::CfgDataW-1:0]  cfg_wdata,
    input  wire logic                              s_valid,
    output      logic                              s_ready,
    input  wire uart_rx_pkg::rx_in_t               s_payload,
    output      logic                              m_valid,
    input  wire logic                              m_ready,
    output      uart_rx_pkg::rx_out_t              m_payload
);
    import uart_rx_pkg::*;

    logic                 nine_bit_reg;
    logic                 end_match_reg;
    logic [ByteW-1:0]     data_mask_reg;

    logic                 busy_reg, busy_next;
    logic [FrameLenW-1:0] remaining_reg, remaining_next;
    logic [FrameLenW-1:0] frame_size_reg, frame_size_next;
    logic [PosW-1:0]      position_reg, position_next;
    logic                 match_irq_reg, match_irq_next;
    logic                 timeout_irq_reg, timeout_irq_next;

    logic                 m_valid_reg, m_valid_next;
    rx_out_t              m_payload_reg, m_payload_next;

    logic                 in_fire;
    event_t               evt;
    logic [PosW-1:0]      pos_base;
    logic [FrameLenW-1:0] rem_base;
    logic [FrameLenW-1:0] rem_dec;
    logic                 len_byte;

    assign s_ready   = !m_valid_reg || m_ready;
    assign in_fire   = s_valid && s_ready;
    assign m_valid   = m_valid_reg;
    assign m_payload = m_payload_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            nine_bit_reg  <= 1'b0;
            end_match_reg <= 1'b0;
            data_mask_reg <= DataMaskReset;
        end else if (cfg_wr_en) begin
            unique case (cfg_addr)
                CFG_NINE_BIT:  nine_bit_reg  <= cfg_wdata[0];
                CFG_END_MATCH: end_match_reg <= cfg_wdata[0];
                CFG_DATA_MASK: data_mask_reg <= cfg_wdata[ByteW-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        busy_next        = busy_reg;
        remaining_next   = remaining_reg;
        frame_size_next  = frame_size_reg;
        position_next    = position_reg;
        match_irq_next   = match_irq_reg;
        timeout_irq_next = timeout_irq_reg;
        evt              = EV_NONE;
        pos_base         = position_reg;
        rem_base         = remaining_reg;
        rem_dec          = remaining_reg - 16'd1;
        len_byte         = 1'b0;
        m_payload_next   = '0;

        unique case (s_payload.opcode)
            OP_ARM: begin
                if (!busy_reg && (s_payload.frame_length != '0)) begin
                    frame_size_next  = s_payload.frame_length;
                    remaining_next   = s_payload.frame_length;
                    position_next    = '0;
                    busy_next        = 1'b1;
                    timeout_irq_next = 1'b1;
                    match_irq_next   = end_match_reg;
                end
            end
            OP_ABANDON: begin
                busy_next      = 1'b0;
                remaining_next = '0;
                position_next  = '0;
            end
            OP_RX_CHAR: begin
                if (busy_reg) begin
                    if (s_payload.match_flag) begin
                        if (s_payload.rx_word[WordW-1] && nine_bit_reg) begin
                            pos_base = '0;
                            rem_base = frame_size_reg;
                            evt      = EV_SOB;
                        end else if (match_irq_reg) begin
                            match_irq_next = 1'b0;
                            evt            = EV_CPLT;
                        end
                    end
                    m_payload_next.write_enable   = 1'b1;
                    m_payload_next.write_position = pos_base;
                    m_payload_next.write_byte     =
                        s_payload.rx_word[ByteW-1:0] & data_mask_reg;
                    position_next  = pos_base + 17'd1;
                    rem_dec        = rem_base - 16'd1;
                    remaining_next = rem_dec;

                    // second byte of a nine-bit frame carries the length
                    len_byte = nine_bit_reg &&
                        (({1'b0, rem_dec} + 17'd2) == {1'b0, frame_size_reg});
                    if (len_byte) begin
                        if ({8'd0, s_payload.rx_word[ByteW-1:0]} < frame_size_reg) begin
                            remaining_next = {8'd0, s_payload.rx_word[ByteW-1:0]};
                        end else begin
                            evt = EV_ABT;
                        end
                    end
                    if ((remaining_next == '0) && (evt != EV_ABT)) begin
                        evt = EV_CPLT;
                    end
                    if (evt == EV_CPLT) begin
                        m_payload_next.zero_terminate = !nine_bit_reg;
                        match_irq_next = 1'b0;
                        busy_next      = 1'b0;
                    end
                end
                if (s_payload.timeout_flag && timeout_irq_reg) begin
                    evt = EV_ABT;
                end
                if (evt == EV_ABT) begin
                    busy_next = 1'b0;
                end
            end
            default: ;
        endcase

        m_payload_next.event_res = evt;
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (in_fire) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg        <= 1'b0;
            remaining_reg   <= '0;
            frame_size_reg  <= '0;
            position_reg    <= '0;
            match_irq_reg   <= 1'b0;
            timeout_irq_reg <= 1'b0;
            m_valid_reg     <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
            if (in_fire) begin
                busy_reg        <= busy_next;
                remaining_reg   <= remaining_next;
                frame_size_reg  <= frame_size_next;
                position_reg    <= position_next;
                match_irq_reg   <= match_irq_next;
                timeout_irq_reg <= timeout_irq_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (in_fire) begin
            m_payload_reg <= m_payload_next;
        end
    end

    a_idle_stays_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        !busy_reg && !(in_fire && (s_payload.opcode == OP_ARM)) |=> !busy_reg)
        else $error("receiver became busy without an arm beat");

    a_idle_no_store: assert property (@(posedge aclk) disable iff (!aresetn)
        in_fire && !busy_reg |=> !m_payload_reg.write_enable)
        else $error("byte stored while not receiving");

    a_abandon_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        in_fire && (s_payload.opcode == OP_ABANDON)
        |=> !busy_reg && (position_reg == '0) && (remaining_reg == '0))
        else $error("abandon did not clear reception state");

    a_arm_loads: assert property (@(posedge aclk) disable iff (!aresetn)
        in_fire && (s_payload.opcode == OP_ARM) && !busy_reg
        && (s_payload.frame_length != '0)
        |=> busy_reg && (remaining_reg == frame_size_reg) && (position_reg == '0))
        else $error("arm did not load the frame counters");

endmodule

`default_nettype wire
